/* src/pawq_pkg.sv */
// shared constants, types and helpers for the peer admission block
`timescale 1ns / 1ps
`default_nettype none
package pawq_pkg;
  localparam int ACTIVE_SLOTS = 16;
  localparam int QUEUE_DEPTH  = 32;
  localparam int ID_BITS      = 8;
  localparam int AW     = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ACNT_W = $clog2(ACTIVE_SLOTS + 1);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ALIM_W = 5;
  localparam int QLIM_W = 6;
  localparam int CFG_DW = 6;

  typedef enum logic [2:0] {
    ST_ADMITTED    = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_BUSY        = 3'd2,
    ST_LEFT_ACTIVE = 3'd3,
    ST_LEFT_QUEUE  = 3'd4,
    ST_UNKNOWN     = 3'd5,
    ST_DUPLICATE   = 3'd6
  } status_t;

  localparam logic OP_JOIN  = 1'b0;
  localparam logic OP_LEAVE = 1'b1;

  localparam logic REG_ACTIVE_LIMIT = 1'b0;
  localparam logic REG_QUEUE_LIMIT  = 1'b1;
endpackage
`default_nettype wire

/* src/pawq_if.sv */
// handshake channel interfaces: request, response and configuration
`timescale 1ns / 1ps
`default_nettype none
interface pawq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [7:0]                  peer_id;
  modport source (output valid, operation, peer_id, input ready);
  modport sink (input valid, operation, peer_id, output ready);
endinterface

interface pawq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        promoted_valid;
  logic [7:0]  promoted_id;
  logic [4:0]  active_count;
  logic [5:0]  waiting_count;
  modport source (output valid, status, promoted_valid, promoted_id, active_count,
                  waiting_count, input ready);
  modport sink (input valid, status, promoted_valid, promoted_id, active_count,
                waiting_count, output ready);
endinterface

interface pawq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic                          index;
  logic [pawq_pkg::CFG_DW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/peer_admission_with_wait_queue.sv */
// top level: admission sequencer over active id and wait queue memories
//
// Requests arrive on req (operation: join or leave, peer_id). Each request
// gives exactly one response on rsp with status, promoted peer and the
// active and waiting counts after the request. Limits are written on cfg
// (index 0 active_limit, index 1 queue_limit); the user must write them
// only while the block is idle, which the block itself does not enforce.
// A limit of zero or above capacity means full capacity.
// One request is processed at a time. The active id memory is swept one
// slot a cycle, then the occupied part of the wait queue, then an apply
// step; a leave from the queue or a promotion then closes the queue up one
// entry a cycle through the single write port, and last the response is
// loaded.
// The response sits in an output register; the next request is accepted
// the cycle after it is loaded, while it waits. If rsp is stalled when a
// second result is ready, the sequencer holds until the register frees.
// Reset clears limits, counts and active valid bits; the memories need no
// clearing.
`timescale 1ns / 1ps
`default_nettype none
module peer_admission_with_wait_queue (
  input wire logic clk,
  input wire logic rst,
  pawq_req_if.sink   req,
  pawq_rsp_if.source rsp,
  pawq_cfg_if.sink   cfg
);
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN_A = 6'b000010,
    S_SCAN_W = 6'b000100,
    S_APPLY  = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;

  logic [pawq_pkg::ALIM_W-1:0]       active_limit;
  logic [pawq_pkg::QLIM_W-1:0]       queue_limit;
  logic [pawq_pkg::ACTIVE_SLOTS-1:0] active_valid;
  logic [pawq_pkg::ACNT_W-1:0]       active_total;
  logic [pawq_pkg::QCNT_W-1:0]       wait_count;

  logic                              op;
  logic [pawq_pkg::ID_BITS-1:0]      id;
  logic [pawq_pkg::ACNT_W-1:0]       a_cnt;
  logic [pawq_pkg::QCNT_W-1:0]       q_cnt;
  logic                              pv;
  logic [pawq_pkg::AW-1:0]           p_aidx;
  logic [pawq_pkg::QW-1:0]           p_qidx;
  logic                              a_hit;
  logic [pawq_pkg::AW-1:0]           a_pos;
  logic                              w_hit;
  logic [pawq_pkg::QW-1:0]           w_pos;
  logic [pawq_pkg::ID_BITS-1:0]      head;
  pawq_pkg::status_t                 status;
  logic                              prom_v;
  logic [pawq_pkg::ID_BITS-1:0]      prom_id;

  // memory ports
  logic                              a_we;
  logic [pawq_pkg::AW-1:0]           a_waddr;
  logic [pawq_pkg::ID_BITS-1:0]      a_wdata;
  logic [pawq_pkg::ID_BITS-1:0]      a_rdata;
  logic                              q_we;
  logic [pawq_pkg::QW-1:0]           q_waddr;
  logic [pawq_pkg::ID_BITS-1:0]      q_wdata;
  logic [pawq_pkg::ID_BITS-1:0]      q_rdata;

  logic [pawq_pkg::ACNT_W-1:0]       eff_alim;
  logic [pawq_pkg::QCNT_W-1:0]       eff_qlim;
  logic [pawq_pkg::ACTIVE_SLOTS-1:0] free_mask;
  logic [pawq_pkg::ACTIVE_SLOTS-1:0] valid_promoted;
  logic [pawq_pkg::AW-1:0]           free_slot;
  logic                              leave_active;
  logic [pawq_pkg::ACNT_W-1:0]       total_less;
  logic                              do_admit;
  logic                              do_queue;
  logic                              do_promote;

  pawq_ram #(.WIDTH(pawq_pkg::ID_BITS), .DEPTH(pawq_pkg::ACTIVE_SLOTS)) u_active_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_cnt[pawq_pkg::AW-1:0]),
    .rdata (a_rdata)
  );

  pawq_ram #(.WIDTH(pawq_pkg::ID_BITS), .DEPTH(pawq_pkg::QUEUE_DEPTH)) u_wait_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_cnt[pawq_pkg::QW-1:0]),
    .rdata (q_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    if (active_limit == '0 || 32'(active_limit) > pawq_pkg::ACTIVE_SLOTS) begin
      eff_alim = pawq_pkg::ACNT_W'(pawq_pkg::ACTIVE_SLOTS);
    end else begin
      eff_alim = pawq_pkg::ACNT_W'(active_limit);
    end
    if (queue_limit == '0 || 32'(queue_limit) > pawq_pkg::QUEUE_DEPTH) begin
      eff_qlim = pawq_pkg::QCNT_W'(pawq_pkg::QUEUE_DEPTH);
    end else begin
      eff_qlim = pawq_pkg::QCNT_W'(queue_limit);
    end
  end

  // lowest free slot, counting the slot a leave is about to free
  always_comb begin
    leave_active = (op == pawq_pkg::OP_LEAVE) && a_hit;
    free_mask = ~active_valid;
    if (leave_active) begin
      free_mask[a_pos] = 1'b1;
    end
    free_slot = '0;
    for (int i = pawq_pkg::ACTIVE_SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_slot = pawq_pkg::AW'(i);
      end
    end
    valid_promoted = ~free_mask;
    valid_promoted[free_slot] = 1'b1;
    total_less = active_total - pawq_pkg::ACNT_W'(1);
    do_admit   = (op == pawq_pkg::OP_JOIN) && !a_hit && !w_hit && (active_total < eff_alim);
    do_queue   = (op == pawq_pkg::OP_JOIN) && !a_hit && !w_hit && !(active_total < eff_alim)
                 && (wait_count < eff_qlim);
    do_promote = leave_active && (wait_count != '0) && (total_less < eff_alim);
  end

  always_comb begin
    a_we    = (state == S_APPLY) && (do_admit || do_promote);
    a_waddr = free_slot;
    a_wdata = do_promote ? head : id;
    if (state == S_SHIFT) begin
      q_we    = pv;
      q_waddr = p_qidx - pawq_pkg::QW'(1);
      q_wdata = q_rdata;
    end else begin
      q_we    = (state == S_APPLY) && do_queue;
      q_waddr = wait_count[pawq_pkg::QW-1:0];
      q_wdata = id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_limit <= '0;
      queue_limit  <= '0;
      active_valid <= '0;
      active_total <= '0;
      wait_count   <= '0;
      pv           <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          pawq_pkg::REG_ACTIVE_LIMIT: active_limit <= cfg.data[pawq_pkg::ALIM_W-1:0];
          pawq_pkg::REG_QUEUE_LIMIT:  queue_limit  <= cfg.data[pawq_pkg::QLIM_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op     <= req.operation;
            id     <= req.peer_id;
            a_cnt  <= '0;
            q_cnt  <= '0;
            pv     <= 1'b0;
            a_hit  <= 1'b0;
            w_hit  <= 1'b0;
            a_pos  <= '0;
            w_pos  <= '0;
            head   <= '0;
            prom_v <= 1'b0;
            prom_id <= '0;
            state  <= S_SCAN_A;
          end
        end
        S_SCAN_A: begin
          pv <= 32'(a_cnt) < pawq_pkg::ACTIVE_SLOTS;
          p_aidx <= a_cnt[pawq_pkg::AW-1:0];
          if (32'(a_cnt) < pawq_pkg::ACTIVE_SLOTS) begin
            a_cnt <= a_cnt + pawq_pkg::ACNT_W'(1);
          end
          if (pv && active_valid[p_aidx] && a_rdata == id && !a_hit) begin
            a_hit <= 1'b1;
            a_pos <= p_aidx;
          end
          if (32'(a_cnt) >= pawq_pkg::ACTIVE_SLOTS && !pv) begin
            state <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          pv <= q_cnt < wait_count;
          p_qidx <= q_cnt[pawq_pkg::QW-1:0];
          if (q_cnt < wait_count) begin
            q_cnt <= q_cnt + pawq_pkg::QCNT_W'(1);
          end
          if (pv) begin
            if (p_qidx == '0) begin
              head <= q_rdata;
            end
            if (q_rdata == id && !w_hit) begin
              w_hit <= 1'b1;
              w_pos <= p_qidx;
            end
          end
          if (q_cnt >= wait_count && !pv) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_DONE;
          pv    <= 1'b0;
          if (op == pawq_pkg::OP_JOIN) begin
            if (a_hit || w_hit) begin
              status <= pawq_pkg::ST_DUPLICATE;
            end else if (do_admit) begin
              status <= pawq_pkg::ST_ADMITTED;
              active_valid[free_slot] <= 1'b1;
              active_total <= active_total + pawq_pkg::ACNT_W'(1);
            end else if (do_queue) begin
              status <= pawq_pkg::ST_QUEUED;
              wait_count <= wait_count + pawq_pkg::QCNT_W'(1);
            end else begin
              status <= pawq_pkg::ST_BUSY;
            end
          end else if (a_hit) begin
            status <= pawq_pkg::ST_LEFT_ACTIVE;
            if (do_promote) begin
              // freed slot may be refilled by the queue head in the same step
              active_valid <= valid_promoted;
              prom_v  <= 1'b1;
              prom_id <= head;
              q_cnt   <= pawq_pkg::QCNT_W'(1);
              state   <= S_SHIFT;
            end else begin
              active_valid[a_pos] <= 1'b0;
              active_total <= total_less;
            end
          end else if (w_hit) begin
            status <= pawq_pkg::ST_LEFT_QUEUE;
            q_cnt  <= pawq_pkg::QCNT_W'(w_pos) + pawq_pkg::QCNT_W'(1);
            state  <= S_SHIFT;
          end else begin
            status <= pawq_pkg::ST_UNKNOWN;
          end
        end
        S_SHIFT: begin
          // read entry behind, write it one place forward next cycle
          pv <= q_cnt < wait_count;
          p_qidx <= q_cnt[pawq_pkg::QW-1:0];
          if (q_cnt < wait_count) begin
            q_cnt <= q_cnt + pawq_pkg::QCNT_W'(1);
          end
          if (q_cnt >= wait_count && !pv) begin
            wait_count <= wait_count - pawq_pkg::QCNT_W'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.status         <= status;
            rsp.promoted_valid <= prom_v;
            rsp.promoted_id    <= prom_id;
            rsp.active_count   <= active_total;
            rsp.waiting_count  <= wait_count;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    active_total == pawq_pkg::ACNT_W'($countones(active_valid)))
    else $error("active count out of step with valid bits");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    32'(wait_count) <= pawq_pkg::QUEUE_DEPTH)
    else $error("wait queue count above depth");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_SCAN_A)
    else $error("accepted request did not start a scan");

  a_promote_id: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.promoted_valid |-> rsp.promoted_id == '0)
    else $error("promoted id set without promotion");
endmodule
`default_nettype wire

/* src/pawq_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pawq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
